FILE: hw/rtl/plr_pkg.sv
// Shared types and constants for the planar line rasterizer.
// No dependencies; imported by every module of the block.
package plr_pkg;

  localparam int unsigned CoordBitsDef = 12;

  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 11;

  localparam int unsigned OffsetBits = 22;
  localparam int unsigned OutDataBits = 40;

  localparam logic [7:0] BitZero   = 8'h80;
  localparam logic [3:0] ColorMask = 4'hF;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_SURFACE_WIDTH  = 3'd0,
    CFG_SURFACE_HEIGHT = 3'd1,
    CFG_ROW_PITCH      = 3'd2,
    CFG_PIXEL_SHIFT    = 3'd3,
    CFG_PEN_COLOR      = 3'd4,
    CFG_PEN_ENABLE     = 3'd5
  } cfg_index_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [10:0] surface_width;
    logic [10:0] surface_height;
    logic [10:0] row_pitch;
    logic [1:0]  pixel_shift;
    logic [3:0]  pen_color;
    logic        pen_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    surface_width:  11'd640,
    surface_height: 11'd480,
    row_pitch:      11'd80,
    pixel_shift:    2'd3,
    pen_color:      4'd15,
    pen_enable:     1'b1
  };

  typedef struct packed {
    logic                  last;
    logic                  inside_res;
    logic [3:0]            color;
    logic [7:0]            bit_mask;
    logic [OffsetBits-1:0] plane_offset;
  } res_t;

  // low bits of x that select the pixel within its byte
  function automatic logic [2:0] bit_index_mask(input logic [1:0] shift);
    logic [2:0] m;
    case (shift)
      2'd0:    m = 3'b000;
      2'd1:    m = 3'b001;
      2'd2:    m = 3'b011;
      default: m = 3'b111;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/plr_walker.sv
// Bresenham walk state: endpoint load and one step per accepted transaction.
// Depends on plr_pkg.
module plr_walker #(
  parameter int unsigned CoordBits = plr_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 step_i,
  input  logic [CoordBits-1:0] start_x_i,
  input  logic [CoordBits-1:0] start_y_i,
  input  logic [CoordBits-1:0] end_x_i,
  input  logic [CoordBits-1:0] end_y_i,
  output logic                 active_o,
  output logic                 fin_o,
  output logic [CoordBits-1:0] cur_x_o,
  output logic [CoordBits-1:0] cur_y_o
);
  import plr_pkg::*;

  localparam int unsigned ErrBits = CoordBits + 2;

  logic signed [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CoordBits-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CoordBits-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                        neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [ErrBits-1:0]   err_q, err_d;
  logic                        active_q, active_d;

  logic signed [CoordBits:0]   diff_x, diff_y;
  logic [CoordBits:0]          mag_x, mag_y;
  logic signed [ErrBits:0]     e2, neg_dy, pos_dx;
  logic                        fin, move_x, move_y;

  assign diff_x = $signed({end_x_i[CoordBits-1], end_x_i})
                - $signed({start_x_i[CoordBits-1], start_x_i});
  assign diff_y = $signed({end_y_i[CoordBits-1], end_y_i})
                - $signed({start_y_i[CoordBits-1], start_y_i});
  assign mag_x  = diff_x[CoordBits] ? $unsigned(-diff_x) : $unsigned(diff_x);
  assign mag_y  = diff_y[CoordBits] ? $unsigned(-diff_y) : $unsigned(diff_y);

  assign fin    = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign e2     = {err_q, 1'b0};
  assign neg_dy = -$signed({3'b000, dy_q});
  assign pos_dx = $signed({3'b000, dx_q});
  assign move_x = e2 >= neg_dy;
  assign move_y = e2 <= pos_dx;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    active_d = active_q;
    if (load_i) begin
      cur_x_d  = $signed(start_x_i);
      cur_y_d  = $signed(start_y_i);
      tgt_x_d  = $signed(end_x_i);
      tgt_y_d  = $signed(end_y_i);
      dx_d     = mag_x[CoordBits-1:0];
      dy_d     = mag_y[CoordBits-1:0];
      neg_x_d  = diff_x[CoordBits] || (diff_x == '0);
      neg_y_d  = diff_y[CoordBits] || (diff_y == '0);
      err_d    = $signed({2'b00, mag_x[CoordBits-1:0]})
               - $signed({2'b00, mag_y[CoordBits-1:0]});
      active_d = 1'b1;
    end else if (step_i && active_q) begin
      if (fin) begin
        active_d = 1'b0;
      end else begin
        // both axes may advance in the same step
        if (move_x) begin
          cur_x_d = neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (move_y) begin
          cur_y_d = neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
        err_d = err_q - (move_x ? $signed({2'b00, dy_q}) : '0)
                      + (move_y ? $signed({2'b00, dx_q}) : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      err_q    <= err_d;
      active_q <= active_d;
    end
  end

  assign active_o = active_q;
  assign fin_o    = fin;
  assign cur_x_o  = cur_x_q;
  assign cur_y_o  = cur_y_q;

endmodule

FILE: hw/rtl/plr_pixel_addr.sv
// Pixel write formation: clip test, byte offset, bit mask and color.
// Depends on plr_pkg.
module plr_pixel_addr #(
  parameter int unsigned CoordBits = plr_pkg::CoordBitsDef
) (
  input  logic [CoordBits-1:0] cur_x_i,
  input  logic [CoordBits-1:0] cur_y_i,
  input  logic                 fin_i,
  input  plr_pkg::cfg_t        cfg_i,
  output plr_pkg::res_t        res_o
);
  import plr_pkg::*;

  localparam int unsigned CmpBits = (CoordBits > 11) ? CoordBits : 11;

  logic [CmpBits-1:0]    ux, uy;
  logic                  on_surf;
  logic [10:0]           x11, y11, x_byte;
  logic [21:0]           row_base;
  logic [OffsetBits-1:0] offset;
  logic [2:0]            bidx;

  // a negative coordinate has its sign bit set and is clipped by that alone
  assign ux = CmpBits'(cur_x_i);
  assign uy = CmpBits'(cur_y_i);
  assign on_surf = !cur_x_i[CoordBits-1] && !cur_y_i[CoordBits-1]
                && (ux < CmpBits'(cfg_i.surface_width))
                && (uy < CmpBits'(cfg_i.surface_height));

  // inside the surface both coordinates fit in 11 bits
  assign x11      = ux[10:0];
  assign y11      = uy[10:0];
  assign x_byte   = x11 >> cfg_i.pixel_shift;
  assign row_base = y11 * cfg_i.row_pitch;
  assign offset   = row_base + OffsetBits'(x_byte);
  assign bidx     = x11[2:0] & bit_index_mask(cfg_i.pixel_shift);

  always_comb begin
    res_o.last         = fin_i;
    res_o.inside_res   = on_surf;
    res_o.color        = cfg_i.pen_color & ColorMask;
    res_o.bit_mask     = on_surf ? (BitZero >> bidx) : '0;
    res_o.plane_offset = on_surf ? offset : '0;
  end

endmodule

FILE: hw/rtl/plr_out_buf.sv
// Result register with one skid entry so input acceptance is decoupled
// from output stalls. Depends on plr_pkg.
module plr_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  plr_pkg::res_t res_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_ready_i,
  output plr_pkg::res_t res_o
);
  import plr_pkg::*;

  logic out_v_q, out_v_d, skid_v_q, skid_v_d;
  res_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || pop_ready_i) begin
      // drain the skid first; no push can arrive while it is full
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = res_i;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = res_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_v_q;
  assign valid_o = out_v_q;
  assign res_o   = out_q;

endmodule

FILE: hw/rtl/planar_line_rasterizer_core.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata endpoints
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata pixel write, tlast last
// cfg       in   cfg_we_i                     cfg_index_i, cfg_data_i
//
// One transaction per cycle while s_axis_tready is high. The walk update and
// the y * pitch multiply share the step's cycle, and its write is registered.
// Reset clears the walk to idle and the registers to their defaults.
// A stalled output holds one result plus one skid entry before s_axis stalls.
// Depends on plr_pkg, plr_walker, plr_pixel_addr and plr_out_buf.
module planar_line_rasterizer_core #(
  parameter int unsigned CoordBits = plr_pkg::CoordBitsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
  input  logic [((4*CoordBits+7)/8)*8-1:0]           s_axis_tdata,
  // opcode
  input  logic                                       s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // plane_offset, bit_mask, color, inside_res from bit 0 up, zero padded
  output logic [plr_pkg::OutDataBits-1:0]            m_axis_tdata,
  output logic                                       m_axis_tlast,
  input  logic                                       cfg_we_i,
  input  logic [plr_pkg::CfgIndexBits-1:0]           cfg_index_i,
  input  logic [plr_pkg::CfgDataBits-1:0]            cfg_data_i
);
  import plr_pkg::*;

  localparam int unsigned ResBits = $bits(res_t) - 1;

  cfg_t cfg_q, cfg_d;
  logic fire, load, step, active, fin, push;
  logic [CoordBits-1:0] cur_x, cur_y;
  res_t res, res_out;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SURFACE_WIDTH:  cfg_d.surface_width  = cfg_data_i[10:0];
        CFG_SURFACE_HEIGHT: cfg_d.surface_height = cfg_data_i[10:0];
        CFG_ROW_PITCH:      cfg_d.row_pitch      = cfg_data_i[10:0];
        CFG_PIXEL_SHIFT:    cfg_d.pixel_shift    = cfg_data_i[1:0];
        CFG_PEN_COLOR:      cfg_d.pen_color      = cfg_data_i[3:0];
        CFG_PEN_ENABLE:     cfg_d.pen_enable     = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign fire = s_axis_tvalid && s_axis_tready;
  assign load = fire && (opcode_e'(s_axis_tuser) == OP_LOAD) && cfg_q.pen_enable;
  assign step = fire && (opcode_e'(s_axis_tuser) == OP_STEP);
  assign push = step && active;

  plr_walker #(
    .CoordBits (CoordBits)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .step_i    (step),
    .start_x_i (s_axis_tdata[CoordBits-1:0]),
    .start_y_i (s_axis_tdata[2*CoordBits-1:CoordBits]),
    .end_x_i   (s_axis_tdata[3*CoordBits-1:2*CoordBits]),
    .end_y_i   (s_axis_tdata[4*CoordBits-1:3*CoordBits]),
    .active_o  (active),
    .fin_o     (fin),
    .cur_x_o   (cur_x),
    .cur_y_o   (cur_y)
  );

  plr_pixel_addr #(
    .CoordBits (CoordBits)
  ) u_pixel_addr (
    .cur_x_i (cur_x),
    .cur_y_i (cur_y),
    .fin_i   (fin),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  plr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .res_o       (res_out)
  );

  assign m_axis_tdata = OutDataBits'(res_out[ResBits-1:0]);
  assign m_axis_tlast = res_out.last;

  // the final pixel of a line always ends the walk
  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && fin |=> !active)
    else $error("walk still active after final pixel");

  // a stalled input side means a result and a skid entry are both held
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_out.inside_res |->
      res_out.plane_offset == '0 && res_out.bit_mask == '0)
    else $error("clipped pixel carries an address");

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_out.inside_res |-> $onehot(res_out.bit_mask))
    else $error("bit mask not one-hot");

endmodule
